// ===== hw/rtl/nis_pkg.sv =====
`default_nettype none

package nis_pkg;

  // register indexes on the configuration port
  localparam logic [1:0] CFG_GUESS  = 2'd0;
  localparam logic [1:0] CFG_THRESH = 2'd1;
  localparam logic [1:0] CFG_LIMIT  = 2'd2;

  // fixed widths of the configuration registers
  localparam int GUESS_CFG_W  = 31;
  localparam int THRESH_CFG_W = 28;
  localparam int LIMIT_CFG_W  = 8;

  // reset values of the configuration registers
  localparam logic [GUESS_CFG_W-1:0]  GUESS_RESET  = 31'd268435456;
  localparam logic [THRESH_CFG_W-1:0] THRESH_RESET = 28'd2684;
  localparam logic [LIMIT_CFG_W-1:0]  LIMIT_RESET  = 8'd64;

  // iterative multiplier chunk width
  localparam int MUL_CHUNK = 16;

  typedef struct packed {
    logic [GUESS_CFG_W-1:0]  initial_guess;
    logic [THRESH_CFG_W-1:0] error_threshold;
    logic [LIMIT_CFG_W-1:0]  iteration_limit;
  } cfg_t;

  // class of an operand as seen by the front end
  typedef enum logic {
    KIND_NORMAL,
    KIND_ZERO
  } kind_t;

  typedef struct packed {
    logic busy;
    logic done;
  } mul_stat_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_G2,
    S_XG2,
    S_CHECK,
    S_T,
    S_UPD,
    S_ROOT,
    S_OUT
  } eng_state_t;

endpackage

`default_nettype wire

// ===== hw/rtl/nis_front.sv =====
`default_nettype none

module nis_front #(
  parameter int VALUE_WIDTH = 24,
  parameter int GUESS_WIDTH = 32,
  parameter int SDW = 24,
  parameter int ITEM_W = 58
) (
  input  wire logic [SDW-1:0]   s_tdata,    // value
  input  wire logic             s_tvalid,
  output logic                  s_tready,
  input  wire logic             s_tlast,    // batch_end
  input  wire nis_pkg::cfg_t    cfg,
  input  wire logic             q_full,
  output logic                  q_push,
  output logic [ITEM_W-1:0]     q_item      // value, batch_end, start guess, kind
);
  import nis_pkg::*;

  localparam int VW = VALUE_WIDTH;
  localparam int GW = GUESS_WIDTH;
  localparam int SW = (GW > GUESS_CFG_W) ? GW : GUESS_CFG_W;

  logic [VW-1:0] value;
  logic [SW-1:0] guess_ext;
  logic [SW-1:0] gmax_ext;
  logic [GW-1:0] guess0;
  kind_t         kind;

  // take a request whenever the queue has room
  assign s_tready = !q_full;
  assign q_push   = s_tvalid && !q_full;

  // classify the operand
  assign value = s_tdata[VW-1:0];
  assign kind  = (value == '0) ? KIND_ZERO : KIND_NORMAL;

  // starting guess clipped to the positive guess range
  assign guess_ext = SW'(cfg.initial_guess);
  assign gmax_ext  = {{(SW-GW+1){1'b0}}, {(GW-1){1'b1}}};
  assign guess0    = (guess_ext > gmax_ext) ? gmax_ext[GW-1:0] : guess_ext[GW-1:0];

  assign q_item = {kind, guess0, s_tlast, value};

endmodule

`default_nettype wire

// ===== hw/rtl/nis_queue.sv =====
`default_nettype none

module nis_queue #(
  parameter int WIDTH = 58
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] push_data,
  output logic                  full,
  input  wire logic             pop,
  output logic                  avail,
  output logic [WIDTH-1:0]      pop_data
);

  // two entry ring between front and back
  logic [WIDTH-1:0] slots [2];
  logic             wr_ptr;
  logic             rd_ptr;
  logic [1:0]       count;
  logic             do_push;
  logic             do_pop;

  assign full     = (count == 2'd2);
  assign avail    = (count != 2'd0);
  assign pop_data = slots[rd_ptr];
  assign do_push  = push && !full;
  assign do_pop   = pop && avail;

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) begin
        wr_ptr <= !wr_ptr;
      end
      if (do_pop) begin
        rd_ptr <= !rd_ptr;
      end
      case ({do_push, do_pop})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_data;
    end
  end

endmodule

`default_nettype wire

// ===== hw/rtl/nis_mul.sv =====
`default_nettype none

module nis_mul #(
  parameter int AW = 36,
  parameter int BW = 32
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 start,
  input  wire logic [AW-1:0]        a,
  input  wire logic [BW-1:0]        b,
  output nis_pkg::mul_stat_t        stat,
  output logic [AW+((BW+nis_pkg::MUL_CHUNK-1)/nis_pkg::MUL_CHUNK)*nis_pkg::MUL_CHUNK-1:0] prod
);
  import nis_pkg::*;

  localparam int CH  = MUL_CHUNK;
  localparam int NCH = (BW + CH - 1) / CH;
  localparam int BP  = NCH * CH;
  localparam int PW  = AW + BP;
  localparam int CNW = $clog2(NCH + 1);

  logic [AW-1:0]    a_r;
  logic [BP-1:0]    b_r;
  logic [PW-1:0]    acc;
  logic [CNW-1:0]   cnt;
  logic             busy;
  logic             done;
  logic [AW+CH-1:0] part;

  // one chunk of b per cycle, top chunk first
  assign part = a_r * b_r[BP-1 -: CH];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= busy && (cnt == CNW'(1));
      if (start && !busy) begin
        busy <= 1'b1;
        cnt  <= CNW'(NCH);
      end else if (busy) begin
        cnt <= cnt - CNW'(1);
        if (cnt == CNW'(1)) begin
          busy <= 1'b0;
        end
      end
    end
  end

  // operand and accumulator datapath
  always_ff @(posedge clk) begin
    if (start && !busy) begin
      a_r <= a;
      b_r <= BP'(b);
      acc <= '0;
    end else if (busy) begin
      acc <= (acc << CH) + PW'(part);
      b_r <= b_r << CH;
    end
  end

  assign stat.busy = busy;
  assign stat.done = done;
  assign prod      = acc;

endmodule

`default_nettype wire

// ===== hw/rtl/nis_engine.sv =====
`default_nettype none

module nis_engine #(
  parameter int VALUE_WIDTH = 24,
  parameter int GUESS_WIDTH = 32,
  parameter int ITEM_W = 58
) (
  input  wire logic                   clk,
  input  wire logic                   rst,
  input  wire nis_pkg::cfg_t          cfg,
  input  wire logic                   q_avail,
  input  wire logic [ITEM_W-1:0]      q_item,
  output logic                        q_pop,
  output logic                        out_valid,
  input  wire logic                   out_ready,
  output logic [VALUE_WIDTH-1:0]      out_root,
  output logic                        out_conv,
  output logic [7:0]                  out_steps,
  output logic                        out_last
);
  import nis_pkg::*;

  localparam int VW    = VALUE_WIDTH;
  localparam int GW    = GUESS_WIDTH;
  localparam int VFRAC = VW - 2;
  localparam int GFRAC = GW - 4;
  localparam int AW    = GW + 4;
  localparam int BW    = (GW > VW) ? GW : VW;
  localparam int BP    = ((BW + MUL_CHUNK - 1) / MUL_CHUNK) * MUL_CHUNK;
  localparam int PW    = AW + BP;
  localparam int NW    = GW + 9;
  localparam int CW    = (GW + 4 > THRESH_CFG_W) ? GW + 4 : THRESH_CFG_W;

  eng_state_t state;
  eng_state_t state_next;

  // working registers
  logic [VW-1:0]   x;
  logic            endf;
  logic [GW-1:0]   g;
  logic [GW+2:0]   g2;
  logic [GW+3:0]   xg2;
  logic [GW+6:0]   t;
  logic [7:0]      steps;
  logic [VW-1:0]   root;
  logic            conv;
  logic            mul_start;

  // control decoded from state
  logic            out_load;
  logic            start_next;

  // multiplier hookup
  logic [AW-1:0]   mul_a;
  logic [BW-1:0]   mul_b;
  logic [PW-1:0]   prod;
  mul_stat_t       mstat;

  // queue entry fields
  logic [VW-1:0]   item_value;
  logic            item_end;
  logic [GW-1:0]   item_guess;
  kind_t           item_kind;

  // combinational datapath
  logic [GW-1:0]   mag;
  logic            g_le_zero;
  logic [GW+3:0]   one_g;
  logic [GW+3:0]   err;
  logic [CW-1:0]   err_ext;
  logic [CW-1:0]   thr_ext;
  logic            err_ok;
  logic            zero_conv;
  logic            keep_going;
  logic signed [NW-1:0] g_ext;
  logic signed [NW-1:0] t_ext;
  logic signed [NW-1:0] st;
  logic signed [NW-1:0] num;
  logic signed [NW-1:0] num_adj;
  logic signed [NW-1:0] half;
  logic signed [NW-1:0] gmax_w;
  logic signed [NW-1:0] gmin_w;
  logic [GW-1:0]   g_new;
  logic [VW+2:0]   root_raw;
  logic [VW-1:0]   root_sat;

  assign item_value = q_item[VW-1:0];
  assign item_end   = q_item[VW];
  assign item_guess = q_item[VW+GW:VW+1];
  assign item_kind  = kind_t'(q_item[VW+GW+1]);

  // magnitude and sign of the guess
  assign mag       = g[GW-1] ? (~g + GW'(1)) : g;
  assign g_le_zero = g[GW-1] || (g == '0);

  // residual against threshold
  assign one_g      = (GW+4)'(1) << GFRAC;
  assign err        = (xg2 >= one_g) ? (xg2 - one_g) : (one_g - xg2);
  assign err_ext    = CW'(err);
  assign thr_ext    = CW'(cfg.error_threshold);
  assign err_ok     = (err_ext <= thr_ext);
  assign zero_conv  = (CW'(one_g) <= thr_ext);
  assign keep_going = !err_ok && (steps < cfg.iteration_limit);

  // newton update (3g - t)/2, truncated toward zero and clipped
  assign g_ext   = {{9{g[GW-1]}}, g};
  assign t_ext   = {2'b00, t};
  assign st      = g[GW-1] ? -t_ext : t_ext;
  assign num     = g_ext + (g_ext <<< 1) - st;
  assign num_adj = num + NW'(num[NW-1]);
  assign half    = num_adj >>> 1;
  assign gmax_w  = {{(NW-GW+1){1'b0}}, {(GW-1){1'b1}}};
  assign gmin_w  = ~gmax_w;
  always_comb begin
    if (half > gmax_w) begin
      g_new = gmax_w[GW-1:0];
    end else if (half < gmin_w) begin
      g_new = gmin_w[GW-1:0];
    end else begin
      g_new = half[GW-1:0];
    end
  end

  // root from product, clipped at full scale
  assign root_raw = prod[GFRAC +: VW+3];
  assign root_sat = (root_raw[VW+2:VW] != 3'b000) ? {VW{1'b1}} : root_raw[VW-1:0];

  // operand select for the shared multiplier
  always_comb begin
    case (state)
      S_G2: begin
        mul_a = AW'(mag);
        mul_b = BW'(mag);
      end
      S_XG2: begin
        mul_a = AW'(g2);
        mul_b = BW'(x);
      end
      S_T: begin
        mul_a = xg2;
        mul_b = BW'(mag);
      end
      S_ROOT: begin
        mul_a = AW'(mag);
        mul_b = BW'(x);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  nis_mul #(
    .AW (AW),
    .BW (BW)
  ) u_mul (
    .clk   (clk),
    .rst   (rst),
    .start (mul_start),
    .a     (mul_a),
    .b     (mul_b),
    .stat  (mstat),
    .prod  (prod)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (q_avail) begin
          state_next = (item_kind == KIND_ZERO) ? S_OUT : S_G2;
        end
      end
      S_G2: begin
        if (mstat.done) begin
          state_next = S_XG2;
        end
      end
      S_XG2: begin
        if (mstat.done) begin
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        if (keep_going) begin
          state_next = S_T;
        end else if (g_le_zero) begin
          state_next = S_OUT;
        end else begin
          state_next = S_ROOT;
        end
      end
      S_T: begin
        if (mstat.done) begin
          state_next = S_UPD;
        end
      end
      S_UPD: begin
        state_next = S_G2;
      end
      S_ROOT: begin
        if (mstat.done) begin
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // outputs of the sequencer
  always_comb begin
    q_pop      = 1'b0;
    out_load   = 1'b0;
    start_next = 1'b0;
    case (state)
      S_IDLE: begin
        q_pop = q_avail;
      end
      S_OUT: begin
        out_load = !out_valid || out_ready;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    case (state_next)
      S_G2, S_XG2, S_T, S_ROOT: begin
        start_next = (state_next != state);
      end
      default: begin
        start_next = 1'b0;
      end
    endcase
  end

  // state, multiplier kick and result slot
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      mul_start <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      mul_start <= start_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // working datapath
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        if (q_avail) begin
          x    <= item_value;
          endf <= item_end;
          g    <= item_guess;
          root <= '0;
          if (item_kind == KIND_ZERO) begin
            conv  <= zero_conv;
            steps <= zero_conv ? 8'd0 : cfg.iteration_limit;
          end else begin
            conv  <= 1'b0;
            steps <= 8'd0;
          end
        end
      end
      S_G2: begin
        if (mstat.done) begin
          g2 <= prod[GFRAC +: GW+3];
        end
      end
      S_XG2: begin
        if (mstat.done) begin
          xg2 <= prod[VFRAC +: GW+4];
        end
      end
      S_CHECK: begin
        conv <= err_ok;
      end
      S_T: begin
        if (mstat.done) begin
          t <= prod[GFRAC +: GW+7];
        end
      end
      S_UPD: begin
        g     <= g_new;
        steps <= steps + 8'd1;
      end
      S_ROOT: begin
        if (mstat.done) begin
          root <= root_sat;
        end
      end
      default: begin
        root <= root;
      end
    endcase
    if (out_load) begin
      out_root  <= root;
      out_conv  <= conv;
      out_steps <= steps;
      out_last  <= endf;
    end
  end

`ifndef SYNTH
  a_start_idle: assert property (@(posedge clk) disable iff (rst)
    mul_start |-> !mstat.busy)
    else $error("multiplier started while busy");

  a_done_in_mul: assert property (@(posedge clk) disable iff (rst)
    mstat.done |-> (state == S_G2 || state == S_XG2 || state == S_T || state == S_ROOT))
    else $error("multiplier result with no consumer");

  a_step_count: assert property (@(posedge clk) disable iff (rst)
    (state == S_UPD) |=> (steps == $past(steps) + 8'd1) && (state == S_G2))
    else $error("step count not advanced on update");

  a_result_loaded: assert property (@(posedge clk) disable iff (rst)
    (state == S_OUT && (!out_valid || out_ready)) |=> out_valid && (state == S_IDLE))
    else $error("result not placed in output slot");
`endif

endmodule

`default_nettype wire

// ===== hw/rtl/newton_inverse_sqrt_root.sv =====
// work: a zero operand needs no multiply; otherwise 3*steps + 3 multiplies per item,
//   one multiply fewer when the final guess is not positive, each multiply taking
//   NCH = ceil(max(GUESS_WIDTH, VALUE_WIDTH) / 16) chunks, which is 2 at the default widths
// flow: the engine takes one item at a time through the shared chunked multiplier,
//   three multiplies per newton step, steps bounded by the iteration limit
// reset: synchronous, clears the queue, sequencer and result slot and loads register defaults
`default_nettype none

module newton_inverse_sqrt_root #(
  parameter int VALUE_WIDTH = 24,
  parameter int GUESS_WIDTH = 32
) (
  input  wire logic                                clk,
  input  wire logic                                rst,
  // configuration write port
  input  wire logic                                cfg_wen,
  input  wire logic [1:0]                          cfg_index,
  input  wire logic [nis_pkg::GUESS_CFG_W-1:0]     cfg_wdata,
  // operand stream
  input  wire logic                                s_tvalid,
  output logic                                     s_tready,
  input  wire logic [((VALUE_WIDTH+7)/8)*8-1:0]    s_tdata,   // value
  input  wire logic                                s_tlast,   // batch_end
  // result stream
  output logic                                     m_tvalid,
  input  wire logic                                m_tready,
  output logic [((VALUE_WIDTH+8+7)/8)*8-1:0]       m_tdata,   // root, steps_used
  output logic                                     m_tuser,   // converged
  output logic                                     m_tlast    // last
);
  import nis_pkg::*;

  localparam int VW     = VALUE_WIDTH;
  localparam int GW     = GUESS_WIDTH;
  localparam int SDW    = ((VW + 7) / 8) * 8;
  localparam int MDW    = ((VW + 8 + 7) / 8) * 8;
  localparam int ITEM_W = VW + GW + 2;

  cfg_t              cfg;
  logic              q_full;
  logic              q_push;
  logic [ITEM_W-1:0] q_in;
  logic              q_avail;
  logic              q_pop;
  logic [ITEM_W-1:0] q_out;
  logic [VW-1:0]     out_root;
  logic [7:0]        out_steps;

  // configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.initial_guess   <= GUESS_RESET;
      cfg.error_threshold <= THRESH_RESET;
      cfg.iteration_limit <= LIMIT_RESET;
    end else if (cfg_wen) begin
      case (cfg_index)
        CFG_GUESS:  cfg.initial_guess   <= cfg_wdata;
        CFG_THRESH: cfg.error_threshold <= cfg_wdata[THRESH_CFG_W-1:0];
        CFG_LIMIT:  cfg.iteration_limit <= cfg_wdata[LIMIT_CFG_W-1:0];
        default:    cfg.iteration_limit <= cfg.iteration_limit;
      endcase
    end
  end

  // front: accept and classify
  nis_front #(
    .VALUE_WIDTH (VW),
    .GUESS_WIDTH (GW),
    .SDW         (SDW),
    .ITEM_W      (ITEM_W)
  ) u_front (
    .s_tdata  (s_tdata),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tlast  (s_tlast),
    .cfg      (cfg),
    .q_full   (q_full),
    .q_push   (q_push),
    .q_item   (q_in)
  );

  // queue between front and back
  nis_queue #(
    .WIDTH (ITEM_W)
  ) u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (q_push),
    .push_data (q_in),
    .full      (q_full),
    .pop       (q_pop),
    .avail     (q_avail),
    .pop_data  (q_out)
  );

  // back: newton iteration sequencer
  nis_engine #(
    .VALUE_WIDTH (VW),
    .GUESS_WIDTH (GW),
    .ITEM_W      (ITEM_W)
  ) u_engine (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .q_avail   (q_avail),
    .q_item    (q_out),
    .q_pop     (q_pop),
    .out_valid (m_tvalid),
    .out_ready (m_tready),
    .out_root  (out_root),
    .out_conv  (m_tuser),
    .out_steps (out_steps),
    .out_last  (m_tlast)
  );

  assign m_tdata = MDW'({out_steps, out_root});

endmodule

`default_nettype wire
